// File: rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
	localparam logic [20:0] SUR_FIRST   = 21'h00D800;
	localparam logic [20:0] SUR_LAST    = 21'h00DFFF;
	localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
	localparam logic [20:0] PAIR_OFFSET = 21'h010000;
	localparam logic [15:0] HI_BASE     = 16'hD800;
	localparam logic [15:0] LO_BASE     = 16'hDC00;

	// Output queue geometry: room for two bursts of two units.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [15:0] code_unit;
		logic        replaced;
		logic        last;
	} unit_t;

	// Units produced by one input byte; count is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] count;
		unit_t      u0;
		unit_t      u1;
	} push_t;

	function automatic unit_t mk_unit(input logic [15:0] code, input logic rep);
		unit_t u;
		u.code_unit = code;
		u.replaced  = rep;
		u.last      = 1'b0;
		return u;
	endfunction

endpackage

// File: rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Input register, sequence state and single-pass decode of one UTF-8 byte
// into zero, one or two UTF-16 code units.
// ----------------------------------------------------------------------------
module u8u16_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_eos,
	input  logic                space_ok,
	output u8u16_pkg::push_t    push
);

	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        valid_s1;

	logic [20:0] pp_q;
	logic [1:0]  pend_q;
	logic [2:0]  len_q;

	logic [20:0] npp;
	logic [1:0]  npend;
	logic [2:0]  nlen;
	logic [1:0]  n;
	logic        lead;
	logic [20:0] cp;
	logic [20:0] vsub;
	logic [2:0]  minlen;
	logic        point_bad;
	u8u16_pkg::unit_t u0;
	u8u16_pkg::unit_t u1;
	logic        fire;

	assign fire     = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eos_s1  <= in_eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q   <= '0;
			pend_q <= '0;
			len_q  <= '0;
		end else if (fire) begin
			pp_q   <= npp;
			pend_q <= npend;
			len_q  <= nlen;
		end
	end

	// Candidate code point if this byte completes the open sequence.
	assign cp   = {pp_q[14:0], byte_s1[5:0]};
	assign vsub = cp - u8u16_pkg::PAIR_OFFSET;

	always_comb begin
		if (cp[20:7] == '0) begin
			minlen = 3'd1;
		end else if (cp[20:11] == '0) begin
			minlen = 3'd2;
		end else if (cp[20:16] == '0) begin
			minlen = 3'd3;
		end else begin
			minlen = 3'd4;
		end
	end

	assign point_bad = (cp >= u8u16_pkg::SUR_FIRST && cp <= u8u16_pkg::SUR_LAST) ||
		(cp > u8u16_pkg::MAX_POINT) || (minlen != len_q);

	always_comb begin
		n     = 2'd0;
		u0    = '0;
		u1    = '0;
		npp   = pp_q;
		npend = pend_q;
		nlen  = len_q;
		lead  = 1'b0;
		if (pend_q != 2'd0) begin
			if (byte_s1[7:6] == 2'b10) begin
				npp   = cp;
				npend = pend_q - 2'd1;
				if (npend == 2'd0) begin
					if (point_bad) begin
						u0 = u8u16_pkg::mk_unit(u8u16_pkg::REPL_UNIT, 1'b1);
						n  = 2'd1;
					end else if (cp[20:16] == '0) begin
						u0 = u8u16_pkg::mk_unit(cp[15:0], 1'b0);
						n  = 2'd1;
					end else begin
						u0 = u8u16_pkg::mk_unit(u8u16_pkg::HI_BASE + {6'd0, vsub[19:10]},
							1'b0);
						u1 = u8u16_pkg::mk_unit(u8u16_pkg::LO_BASE + {6'd0, vsub[9:0]},
							1'b0);
						n  = 2'd2;
					end
					npp  = '0;
					nlen = '0;
				end
			end else begin
				// Missing continuation: replace, then treat the byte as a new lead.
				u0    = u8u16_pkg::mk_unit(u8u16_pkg::REPL_UNIT, 1'b1);
				n     = 2'd1;
				npp   = '0;
				npend = '0;
				nlen  = '0;
				lead  = 1'b1;
			end
		end else begin
			lead = 1'b1;
		end

		if (lead) begin
			if (byte_s1[7] == 1'b0) begin
				if (n == 2'd0) begin
					u0 = u8u16_pkg::mk_unit({8'd0, byte_s1}, 1'b0);
				end else begin
					u1 = u8u16_pkg::mk_unit({8'd0, byte_s1}, 1'b0);
				end
				n = n + 2'd1;
			end else if (byte_s1[7:5] == 3'b110) begin
				npp   = {16'd0, byte_s1[4:0]};
				npend = 2'd1;
				nlen  = 3'd2;
			end else if (byte_s1[7:4] == 4'b1110) begin
				npp   = {17'd0, byte_s1[3:0]};
				npend = 2'd2;
				nlen  = 3'd3;
			end else if (byte_s1[7:3] == 5'b11110) begin
				npp   = {18'd0, byte_s1[2:0]};
				npend = 2'd3;
				nlen  = 3'd4;
			end else begin
				if (n == 2'd0) begin
					u0 = u8u16_pkg::mk_unit(u8u16_pkg::REPL_UNIT, 1'b1);
				end else begin
					u1 = u8u16_pkg::mk_unit(u8u16_pkg::REPL_UNIT, 1'b1);
				end
				n = n + 2'd1;
			end
		end

		// A sequence left open at the end of the string is closed with one replacement.
		if (eos_s1 && npend != 2'd0) begin
			if (n == 2'd0) begin
				u0 = u8u16_pkg::mk_unit(u8u16_pkg::REPL_UNIT, 1'b1);
			end else begin
				u1 = u8u16_pkg::mk_unit(u8u16_pkg::REPL_UNIT, 1'b1);
			end
			n     = n + 2'd1;
			npp   = '0;
			npend = '0;
			nlen  = '0;
		end

		if (n == 2'd1) begin
			u0.last = 1'b1;
		end
		if (n == 2'd2) begin
			u1.last = 1'b1;
		end
	end

	assign push.count = fire ? n : 2'd0;
	assign push.u0    = u0;
	assign push.u1    = u1;

`ifndef SYNTHESIS
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.u1.last && !push.u0.last)
		else $error("second unit of a pair must carry the end-of-run mark alone");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd1 |-> push.u0.last)
		else $error("single unit must carry the end-of-run mark");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 |-> pp_q == '0 && len_q == '0)
		else $error("sequence state not cleared while no sequence is open");

	a_repl_code: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 && push.u0.replaced |-> push.u0.code_unit == u8u16_pkg::REPL_UNIT)
		else $error("replaced unit does not hold the replacement code");
`endif

endmodule

// File: rtl/u8u16_outq.sv
// ----------------------------------------------------------------------------
// u8u16_outq
// Small output queue that takes up to two code units a cycle and hands
// one unit a cycle to the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module u8u16_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  u8u16_pkg::push_t    push,
	output logic                space_ok,
	output logic                out_valid,
	input  logic                out_ready,
	output u8u16_pkg::unit_t    out_unit
);

	u8u16_pkg::unit_t mem_q [u8u16_pkg::QDEPTH];

	logic [u8u16_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [u8u16_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [u8u16_pkg::QCNT_W-1:0] count_q;
	logic [u8u16_pkg::QPTR_W-1:0] wr_ptr_p1;
	logic                         pop;

	assign space_ok  = count_q <= u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_unit  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr_p1 = wr_ptr_q + u8u16_pkg::QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.u0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.u1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + u8u16_pkg::QPTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + u8u16_pkg::QPTR_W'(pop);
			count_q  <= count_q + u8u16_pkg::QCNT_W'(push.count) - u8u16_pkg::QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH))
		else $error("output queue over capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> space_ok)
		else $error("units pushed without room for a pair");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd0 && !pop |=> count_q == $past(count_q))
		else $error("queue fill changed with no push and no pop");
`endif

endmodule

// File: rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, replacing malformed
// sequences with U+FFFD.
// ----------------------------------------------------------------------------
//  channel  dir  tdata            tuser     tlast
//  s_*      in   byte_in[7:0]     -         end_of_string
//  m_*      out  code_unit[15:0]  replaced  last_of_run
//
// One byte is accepted every cycle while input is not stalled; its units
// leave one per cycle while m_tready is high, passing through the input
// register and then the output queue. A byte that yields a surrogate pair
// or a replacement plus a unit puts two units in the queue; the four-entry
// queue absorbs such bursts, and input stalls only while it holds more than
// two units. Reset clears the open sequence and empties the queue.
module utf8_to_utf16_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tuser,   // [0] replaced
	output logic        m_tlast
);

	u8u16_pkg::push_t push;
	u8u16_pkg::unit_t out_unit;
	logic             space_ok;

	u8u16_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_eos   (s_tlast),
		.space_ok (space_ok),
		.push     (push)
	);

	u8u16_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_unit  (out_unit)
	);

	assign m_tdata = out_unit.code_unit;
	assign m_tuser = out_unit.replaced;
	assign m_tlast = out_unit.last;

endmodule
